// ----- sv/ssfw_pkg.sv -----
// ----------------------------------------------------------------------------
// ssfw_pkg
// Shared types, codes and the segment table of the seven-segment frame writer.
// ----------------------------------------------------------------------------
package ssfw_pkg;

	localparam int MAX_DIGITS = 4;
	localparam int DIG_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int LEN_W      = $clog2(MAX_DIGITS + 1);
	localparam int FIFO_DEPTH = 2;

	localparam logic [7:0]  DATA_CMD  = 8'h40;
	localparam logic [7:0]  ADDR_CMD  = 8'hC0;
	localparam logic [7:0]  CTRL_CMD  = 8'h80;
	localparam logic [7:0]  SEG_MINUS = 8'h40;
	localparam logic [15:0] RECIP10   = 16'd52429;

	typedef enum logic [1:0] {
		CMD_DEC  = 2'd0,
		CMD_HEX  = 2'd1,
		CMD_RAW  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		SYM_START = 2'd0,
		SYM_BYTE  = 2'd1,
		SYM_STOP  = 2'd2
	} sym_t;

	localparam logic CFG_BRIGHTNESS = 1'b0;
	localparam logic CFG_DISPLAY_ON = 1'b1;

	typedef struct packed {
		logic [1:0]                  pos;
		logic [LEN_W-1:0]            len;
		logic [MAX_DIGITS-1:0][7:0] dig;
	} ssfw_desc_t;

	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'h0: s = 8'h3F;
			4'h1: s = 8'h06;
			4'h2: s = 8'h5B;
			4'h3: s = 8'h4F;
			4'h4: s = 8'h66;
			4'h5: s = 8'h6D;
			4'h6: s = 8'h7D;
			4'h7: s = 8'h07;
			4'h8: s = 8'h7F;
			4'h9: s = 8'h6F;
			4'hA: s = 8'h77;
			4'hB: s = 8'h7C;
			4'hC: s = 8'h39;
			4'hD: s = 8'h5E;
			4'hE: s = 8'h79;
			default: s = 8'h71;
		endcase
		return s;
	endfunction

endpackage

// ----- sv/ssfw_front.sv -----
// ----------------------------------------------------------------------------
// ssfw_front
// Accepts commands, forms the segment bytes of numbers one digit per cycle, queues them.
// ----------------------------------------------------------------------------
module ssfw_front import ssfw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cmd_t             in_cmd,
	input  logic [15:0]      in_value,
	input  logic             in_negative,
	input  logic [1:0]       in_pos,
	input  logic [2:0]       in_count,
	input  logic [3:0]       in_dots,
	input  logic             in_lead,
	input  logic [3:0][7:0]  in_seg,
	output logic             push,
	output ssfw_desc_t       push_desc,
	input  logic             full
);

	logic                  busy_q, done_q;
	logic [15:0]           num_q;
	logic                  neg_q, lead_q, hex_q;
	logic [DIG_W-1:0]      idx_q;
	logic [MAX_DIGITS-1:0] dmask_q;
	ssfw_desc_t            desc_q;

	logic                  accept;
	logic [2:0]            len3;
	logic [LEN_W-1:0]      len_c;
	logic [MAX_DIGITS-1:0] dmask_c;
	logic [MAX_DIGITS-1:0][7:0] raw_c;
	logic [MAX_DIGITS-1:0][7:0] init_c;
	logic [31:0]           prod;
	logic [15:0]           q_dec, r_dec, q_nxt;
	logic [3:0]            r_nxt;
	logic                  zero;
	logic [7:0]            s_nxt;

	assign push      = done_q && !full;
	assign push_desc = desc_q;
	assign in_ready  = !busy_q && (!done_q || !full);
	assign accept    = in_valid && in_ready;

	always_comb begin
		if (in_count == 3'd0) begin
			len3 = 3'd1;
		end else if (32'(in_count) > MAX_DIGITS) begin
			len3 = 3'(MAX_DIGITS);
		end else begin
			len3 = in_count;
		end
		len_c = LEN_W'(len3);
		for (int i = 0; i < MAX_DIGITS; i++) begin
			dmask_c[i] = (i < 4) ? in_dots[3 - (i % 4)] : 1'b0;
			raw_c[i]   = (i < 4 && i < 32'(len3)) ? in_seg[i % 4] : 8'h00;
		end
		init_c = '0;
		if (in_cmd == CMD_RAW) begin
			init_c = raw_c;
		end else if (in_value == 16'd0 && !in_lead) begin
			init_c[DIG_W'(len3 - 3'd1)] = seg_code(4'h0);
		end
	end

	always_comb begin
		prod  = num_q * RECIP10;
		q_dec = 16'(prod[31:19]);
		r_dec = num_q - ((q_dec << 3) + (q_dec << 1));
		q_nxt = hex_q ? (num_q >> 4) : q_dec;
		r_nxt = hex_q ? num_q[3:0] : r_dec[3:0];
		zero  = (num_q == 16'd0);
		s_nxt = (zero && !lead_q) ? 8'h00 : seg_code(r_nxt);
		if (zero && neg_q) begin
			s_nxt = SEG_MINUS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (accept && in_cmd != CMD_NONE) begin
				if (in_cmd == CMD_RAW || (in_value == 16'd0 && !in_lead)) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					if (push) begin
						done_q <= 1'b0;
					end
				end
			end else if (busy_q && idx_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else if (push) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_q.pos <= in_pos;
			desc_q.len <= len_c;
			desc_q.dig <= init_c;
			num_q      <= in_value;
			neg_q      <= in_negative && (in_cmd == CMD_DEC);
			lead_q     <= in_lead;
			hex_q      <= (in_cmd == CMD_HEX);
			idx_q      <= DIG_W'(len3 - 3'd1);
			dmask_q    <= dmask_c;
		end else if (busy_q) begin
			desc_q.dig[idx_q] <= {s_nxt[7] | dmask_q[idx_q], s_nxt[6:0]};
			num_q <= q_nxt;
			idx_q <= idx_q - DIG_W'(1);
			if (zero) begin
				neg_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/ssfw_fifo.sv -----
// ----------------------------------------------------------------------------
// ssfw_fifo
// Short queue of digit descriptors between the front and back parts.
// ----------------------------------------------------------------------------
module ssfw_fifo import ssfw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ssfw_desc_t push_desc,
	output logic       full,
	input  logic       pop,
	output ssfw_desc_t pop_desc,
	output logic       empty
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	ssfw_desc_t       mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (32'(cnt_q) == FIFO_DEPTH);
	assign empty    = (cnt_q == '0);
	assign pop_desc = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == FIFO_DEPTH - 1) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == FIFO_DEPTH - 1) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_desc;
		end
	end

endmodule

// ----- sv/ssfw_back.sv -----
// ----------------------------------------------------------------------------
// ssfw_back
// Symbol sequencer: plays the three display frames of one descriptor.
// ----------------------------------------------------------------------------
module ssfw_back import ssfw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	output logic       pop,
	input  ssfw_desc_t pop_desc,
	input  logic [2:0] brightness,
	input  logic       display_on,
	output logic       out_valid,
	input  logic       out_ready,
	output sym_t       out_kind,
	output logic [7:0] out_byte,
	output logic       out_last
);

	localparam int MAX_SYMS = 9 + MAX_DIGITS;
	localparam int STEP_W   = $clog2(MAX_SYMS);

	logic              active_q;
	ssfw_desc_t        desc_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q, out_last_q;
	sym_t              out_kind_q;
	logic [7:0]        out_byte_q;

	logic              emit, fin;
	sym_t              kind_c;
	logic [7:0]        byte_c;
	logic [STEP_W-1:0] dpos, tpos;

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	always_comb begin
		dpos   = step_q - STEP_W'(5);
		tpos   = dpos - STEP_W'(desc_q.len);
		kind_c = SYM_START;
		byte_c = 8'h00;
		fin    = 1'b0;
		if (step_q < STEP_W'(5)) begin
			unique case (step_q[2:0])
				3'd1: begin kind_c = SYM_BYTE; byte_c = DATA_CMD; end
				3'd2: kind_c = SYM_STOP;
				3'd4: begin kind_c = SYM_BYTE; byte_c = ADDR_CMD + {6'd0, desc_q.pos}; end
				default: kind_c = SYM_START;
			endcase
		end else if (dpos < STEP_W'(desc_q.len)) begin
			kind_c = SYM_BYTE;
			byte_c = desc_q.dig[dpos[DIG_W-1:0]];
		end else begin
			unique case (tpos[1:0])
				2'd0: kind_c = SYM_STOP;
				2'd1: kind_c = SYM_START;
				2'd2: begin
					kind_c = SYM_BYTE;
					byte_c = CTRL_CMD | {4'd0, display_on, brightness};
				end
				default: begin kind_c = SYM_STOP; fin = 1'b1; end
			endcase
		end
	end

	assign emit = active_q && (!out_valid_q || out_ready);
	assign pop  = !empty && (!active_q || (emit && fin));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end else if (emit) begin
				step_q <= step_q + STEP_W'(1);
				if (fin) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= pop_desc;
		end
		if (emit) begin
			out_kind_q <= kind_c;
			out_byte_q <= byte_c;
			out_last_q <= fin;
		end
	end

endmodule

// ----- sv/seven_segment_number_frame_writer.sv -----
// ----------------------------------------------------------------------------
// seven_segment_number_frame_writer
// Turns number and raw-segment commands into start / byte / stop symbols.
// ----------------------------------------------------------------------------
//  channel   signals                          word
//  s_axis    s_tvalid s_tready s_tdata s_tuser  one display command
//  m_axis    m_tvalid m_tready m_tdata m_tuser  one frame symbol, m_tlast on final stop
//  cfg       cfg_valid cfg_ready                one register write
//
//  A command yields 9 + digit count (clamped to 1..4) symbols, one a cycle
//  from the back sequencer while m_tready allows.
//  The front forms one digit a cycle (divide by 10 via reciprocal multiply).
//  A two-deep queue lets the front take new commands while the back still plays.
//  Reset clears all control state; brightness resets to 7, display on.
//  Command code 3 is accepted and dropped.
// ----------------------------------------------------------------------------
module seven_segment_number_frame_writer import ssfw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// value[15:0] negative[16] start_position[18:17] digit_count[21:19]
	// dots[25:22] show_leading_zeros[26] seg0[34:27] seg1[42:35]
	// seg2[50:43] seg3[58:51], zero fill to 63
	input  logic [63:0] s_tdata,
	// cmd[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// byte_value[7:0]
	output logic [7:0]  m_tdata,
	// symbol_kind[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_data
);

	logic [2:0]  brightness_q;
	logic        display_on_q;
	logic        push, pop, full, empty;
	ssfw_desc_t  push_desc, pop_desc;
	sym_t        out_kind;
	logic [3:0][7:0] segs;

	assign cfg_ready = 1'b1;
	assign segs = {s_tdata[58:51], s_tdata[50:43], s_tdata[42:35], s_tdata[34:27]};
	assign m_tuser = out_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= 3'd7;
			display_on_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BRIGHTNESS: brightness_q <= cfg_data;
				CFG_DISPLAY_ON: display_on_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ssfw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_cmd      (cmd_t'(s_tuser)),
		.in_value    (s_tdata[15:0]),
		.in_negative (s_tdata[16]),
		.in_pos      (s_tdata[18:17]),
		.in_count    (s_tdata[21:19]),
		.in_dots     (s_tdata[25:22]),
		.in_lead     (s_tdata[26]),
		.in_seg      (segs),
		.push        (push),
		.push_desc   (push_desc),
		.full        (full)
	);

	ssfw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (full),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.empty     (empty)
	);

	ssfw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.pop        (pop),
		.pop_desc   (pop_desc),
		.brightness (brightness_q),
		.display_on (display_on_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (out_kind),
		.out_byte   (m_tdata),
		.out_last   (m_tlast)
	);

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the seven-segment frame writer against its own frame predictor.
// Commands go in on the s-side stream; every start, byte and stop word that
// comes out is compared with the oldest predicted word. Directed commands hit
// the edge cases (blanked zero, minus placement, overflow, clamped counts,
// raw bytes, the dropped code), then random traffic runs under several idle
// and stall mixes, a long output hold-off and register writes between phases.
// ----------------------------------------------------------------------------
module testbench;
	import ssfw_pkg::*;

	localparam int         QUIET_LIMIT  = 5000;
	localparam int         SETTLE_TICKS = 40;
	localparam logic [7:0] DOT_BIT      = 8'h80;
	localparam logic [7:0] LIGHT_ON_BIT = 8'h08;
	localparam logic [15:0][7:0] GLYPHS = {
		8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
		8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
	};

	typedef struct packed {
		cmd_t             cmd;
		logic [15:0]      value;
		logic             negative;
		logic [1:0]       start_pos;
		logic [2:0]       digit_count;
		logic [3:0]       dots;
		logic             lead_zeros;
		logic [3:0][7:0]  seg;
	} display_cmd_t;

	typedef struct packed {
		sym_t       kind;
		logic [7:0] octet;
		logic       last;
	} frame_symbol_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// value[15:0] negative[16] start_position[18:17] digit_count[21:19]
	// dots[25:22] show_leading_zeros[26] seg0..seg3[58:27], zero fill to 63
	logic [63:0] s_tdata = '0;
	// cmd[1:0]
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// byte_value[7:0]
	logic [7:0]  m_tdata;
	// symbol_kind[1:0]
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [2:0]  cfg_data = '0;

	frame_symbol_t expected_symbols[$];
	int          errors = 0;
	int          quiet_cycles = 0;
	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	int          hold_left = 0;
	logic [2:0]  shadow_brightness = 3'd7;
	logic        shadow_display_on = 1'b1;

	seven_segment_number_frame_writer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		frame_symbol_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_symbols.size() == 0) begin
				$error("unexpected word: kind %0d byte %h last %0d", m_tuser, m_tdata, m_tlast);
				errors++;
			end else begin
				want = expected_symbols.pop_front();
				if (m_tuser !== want.kind) begin
					$error("symbol_kind: expected %0d, got %0d", want.kind, m_tuser);
					errors++;
				end
				if (m_tdata !== want.octet) begin
					$error("byte_value: expected %h, got %h", want.octet, m_tdata);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	task automatic push_symbol(input sym_t kind, input logic [7:0] octet, input logic last);
		frame_symbol_t s;
		s.kind  = kind;
		s.octet = octet;
		s.last  = last;
		expected_symbols.push_back(s);
	endtask

	task automatic predict_frames(input display_cmd_t c);
		logic [7:0] digits [MAX_DIGITS];
		int len;
		int radix;
		int num;
		bit minus;
		int k;
		if (c.cmd == CMD_NONE)
			return;
		len = c.digit_count;
		if (len < 1)
			len = 1;
		if (len > MAX_DIGITS)
			len = MAX_DIGITS;
		for (k = 0; k < MAX_DIGITS; k++)
			digits[k] = 8'h00;
		if (c.cmd == CMD_RAW) begin
			for (k = 0; k < len; k++)
				digits[k] = c.seg[k];
		end else begin
			radix = (c.cmd == CMD_DEC) ? 10 : 16;
			minus = (c.cmd == CMD_DEC) && c.negative;
			num = c.value;
			if (num == 0 && !c.lead_zeros) begin
				digits[len-1] = GLYPHS[0];
			end else begin
				for (k = len - 1; k >= 0; k--) begin
					if (num == 0 && !c.lead_zeros)
						digits[k] = 8'h00;
					else
						digits[k] = GLYPHS[num % radix];
					if (num == 0 && minus) begin
						digits[k] = SEG_MINUS;
						minus = 1'b0;
					end
					num = num / radix;
				end
				for (k = 0; k < len; k++)
					if (c.dots[3-k])
						digits[k] = digits[k] | DOT_BIT;
			end
		end
		push_symbol(SYM_START, 8'h00, 1'b0);
		push_symbol(SYM_BYTE, DATA_CMD, 1'b0);
		push_symbol(SYM_STOP, 8'h00, 1'b0);
		push_symbol(SYM_START, 8'h00, 1'b0);
		push_symbol(SYM_BYTE, ADDR_CMD + c.start_pos, 1'b0);
		for (k = 0; k < len; k++)
			push_symbol(SYM_BYTE, digits[k], 1'b0);
		push_symbol(SYM_STOP, 8'h00, 1'b0);
		push_symbol(SYM_START, 8'h00, 1'b0);
		push_symbol(SYM_BYTE, CTRL_CMD | (shadow_display_on ? LIGHT_ON_BIT : 8'h00)
			| shadow_brightness, 1'b0);
		push_symbol(SYM_STOP, 8'h00, 1'b1);
	endtask

	// entered and left at a falling edge; valid stays high into the next word
	task automatic send_command(input display_cmd_t c);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c.cmd;
		s_tdata  <= {5'd0, c.seg, c.lead_zeros, c.dots, c.digit_count, c.start_pos,
			c.negative, c.value};
		predict_frames(c);
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic await_idle();
		s_tvalid <= 1'b0;
		while (expected_symbols.size() != 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [2:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_BRIGHTNESS)
			shadow_brightness = val;
		else
			shadow_display_on = val[0];
		@(negedge clk);
	endtask

	function automatic display_cmd_t make_command(input cmd_t cmd, input logic [15:0] value,
		input logic negative, input logic [1:0] pos, input logic [2:0] count,
		input logic [3:0] dots, input logic lead, input logic [31:0] segs);
		display_cmd_t c;
		c.cmd         = cmd;
		c.value       = value;
		c.negative    = negative;
		c.start_pos   = pos;
		c.digit_count = count;
		c.dots        = dots;
		c.lead_zeros  = lead;
		c.seg         = segs;
		return c;
	endfunction

	function automatic display_cmd_t random_command();
		display_cmd_t c;
		c = '0;
		c.cmd = ($urandom_range(15) == 0) ? CMD_NONE : cmd_t'(2'($urandom_range(2)));
		case ($urandom_range(3))
			0: c.value = 16'($urandom_range(15));
			1: c.value = 16'($urandom_range(999));
			2: c.value = 16'($urandom_range(9999));
			default: c.value = 16'($urandom);
		endcase
		c.negative    = 1'($urandom_range(1));
		c.start_pos   = 2'($urandom_range(3));
		c.digit_count = ($urandom_range(4) == 0) ? 3'($urandom_range(7))
			: 3'($urandom_range(4, 1));
		c.dots        = 4'($urandom_range(15));
		c.lead_zeros  = 1'($urandom_range(1));
		c.seg         = $urandom;
		return c;
	endfunction

	task automatic test_directed();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		// blanked zero, shown zeros with minus, overflow, minus with no room
		send_command(make_command(CMD_DEC, 16'd0, 1'b1, 2'd0, 3'd4, 4'hF, 1'b0, '0));
		send_command(make_command(CMD_DEC, 16'd0, 1'b1, 2'd1, 3'd4, 4'h0, 1'b1, '0));
		send_command(make_command(CMD_DEC, 16'd65535, 1'b1, 2'd3, 3'd4, 4'hF, 1'b0, '0));
		send_command(make_command(CMD_DEC, 16'd42, 1'b1, 2'd0, 3'd4, 4'hA, 1'b0, '0));
		send_command(make_command(CMD_DEC, 16'd42, 1'b1, 2'd0, 3'd4, 4'h5, 1'b1, '0));
		send_command(make_command(CMD_DEC, 16'd9, 1'b1, 2'd2, 3'd1, 4'h8, 1'b0, '0));
		send_command(make_command(CMD_DEC, 16'd5, 1'b0, 2'd0, 3'd3, 4'h0, 1'b1, '0));
		// clamped counts
		send_command(make_command(CMD_DEC, 16'd7, 1'b0, 2'd1, 3'd0, 4'hF, 1'b0, '0));
		send_command(make_command(CMD_DEC, 16'd1234, 1'b0, 2'd3, 3'd7, 4'h1, 1'b0, '0));
		send_command(make_command(CMD_HEX, 16'hFFFF, 1'b1, 2'd0, 3'd4, 4'hF, 1'b0, '0));
		send_command(make_command(CMD_HEX, 16'hABCD, 1'b0, 2'd2, 3'd2, 4'h3, 1'b0, '0));
		send_command(make_command(CMD_HEX, 16'h0000, 1'b1, 2'd0, 3'd1, 4'h1, 1'b0, '0));
		send_command(make_command(CMD_HEX, 16'h0000, 1'b0, 2'd0, 3'd5, 4'hF, 1'b1, '0));
		send_command(make_command(CMD_RAW, 16'hFFFF, 1'b1, 2'd0, 3'd4, 4'hF, 1'b1, 32'hAA55FF00));
		send_command(make_command(CMD_RAW, 16'd0, 1'b0, 2'd3, 3'd0, 4'h0, 1'b0, 32'h000000FF));
		send_command(make_command(CMD_RAW, 16'd0, 1'b0, 2'd1, 3'd6, 4'h0, 1'b0, 32'h12345678));
		send_command(make_command(CMD_NONE, 16'hFFFF, 1'b1, 2'd3, 3'd4, 4'hF, 1'b1, '1));
		send_command(make_command(CMD_DEC, 16'd99, 1'b1, 2'd0, 3'd4, 4'h0, 1'b0, '0));
		await_idle();
	endtask

	task automatic test_register_extremes();
		write_register(CFG_BRIGHTNESS, 3'd0);
		write_register(CFG_DISPLAY_ON, 3'd0);
		repeat (3) send_command(random_command());
		await_idle();
		write_register(CFG_BRIGHTNESS, 3'd7);
		write_register(CFG_DISPLAY_ON, 3'd1);
		repeat (3) send_command(random_command());
		await_idle();
	endtask

	task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count);
		write_register(CFG_BRIGHTNESS, 3'($urandom_range(7)));
		write_register(CFG_DISPLAY_ON, 3'($urandom_range(1)));
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		repeat (count) send_command(random_command());
		await_idle();
	endtask

	task automatic test_output_hold_off();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_left      = 300;
		repeat (10) send_command(random_command());
		await_idle();
	endtask

	task automatic test_sender_pause();
		src_idle_pct   = 0;
		sink_stall_pct = 30;
		repeat (5) begin
			send_command(random_command());
			await_idle();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_register_extremes();
		test_random_traffic(0, 0, 80);
		test_random_traffic(63, 0, 80);
		test_random_traffic(0, 63, 80);
		test_random_traffic(12, 12, 80);
		test_output_hold_off();
		test_sender_pause();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
